/* design/ppq_pkg.sv */
// Package for the process priority queue: record layout, operation and
// status codes, compare modes. No dependencies.
package ppq_pkg;

   typedef struct packed {
      logic [15:0] id;
      logic [15:0] arrival;
      logic [15:0] burst;
      logic [7:0]  prio;
   } rec_type;

   typedef enum logic [1:0] {
      FUNC_INSERT = 2'd0,
      FUNC_APPEND = 2'd1,
      FUNC_POP    = 2'd2,
      FUNC_REMOVE = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_EMPTY     = 2'd1,
      STATUS_NOT_FOUND = 2'd2,
      STATUS_FULL      = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CMP_PRIO = 2'd0,
      CMP_ID   = 2'd1,
      CMP_ANY  = 2'd2
   } cmp_mode_type;

endpackage

/* design/ppq_if.sv */
// Valid/ready channel interfaces for the process priority queue requests
// and responses. No dependencies.
interface ppq_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  func;
   logic [15:0] proc_id;
   logic [15:0] arrival;
   logic [15:0] burst;
   logic [7:0]  prio;

   modport source (output valid, func, proc_id, arrival, burst, prio, input ready);
   modport sink (input valid, func, proc_id, arrival, burst, prio, output ready);
endinterface

interface ppq_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [15:0] out_id;
   logic [15:0] out_arrival;
   logic [15:0] out_burst;
   logic [7:0]  out_prio;
   logic [4:0]  occupancy;

   modport source (output valid, status, out_id, out_arrival, out_burst, out_prio,
                   occupancy, input ready);
   modport sink (input valid, status, out_id, out_arrival, out_burst, out_prio,
                 occupancy, output ready);
endinterface

/* design/ppq_ram.sv */
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module ppq_ram #(
   parameter int WIDTH = 56,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/ppq_cmp.sv */
// Shared record comparator of the process priority queue scan.
// Depends on ppq_pkg.
module ppq_cmp (
   input  ppq_pkg::cmp_mode_type mode,
   input  ppq_pkg::rec_type      entry,
   input  ppq_pkg::rec_type      key,
   output logic                  hit
);

   always_comb begin
      case (mode)
         ppq_pkg::CMP_PRIO: hit = (entry.prio >= key.prio);
         ppq_pkg::CMP_ID:   hit = (entry.id == key.id);
         ppq_pkg::CMP_ANY:  hit = 1'b1;
         default:           hit = 1'b0;
      endcase
   end

endmodule

/* design/process_priority_queue.sv */
// Process priority queue top level: sequencer over the record RAM and the
// shared comparator. Depends on ppq_pkg, ppq_if, ppq_ram and ppq_cmp.
//
// Holds up to QUEUE_DEPTH process records in queue order in one RAM and
// serves one operation at a time; req_chan.ready is high only while idle.
// Every record visit goes through the RAM's single registered read port. An
// append or an insert into an empty queue writes the record straight in, and
// a full or empty failure goes straight to the result. Otherwise a pop, a
// remove or an insert scans from the front. An insert that meets a stored
// record whose priority is not below its own shifts that record and the rest
// up by one place and writes itself into the gap, else it lands at the back.
// A pop or a remove shifts the records behind its match down by one place; a
// remove that finds no match returns not found. The result is held in an
// output register and one transfer is made per operation; while the receiver
// stalls, the next operation waits for that register before it completes.
module process_priority_queue #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic            clock,
   input  logic            reset,
   ppq_req_if.sink         req_chan,
   ppq_rsp_if.source       rsp_chan
);

   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int RW = $bits(ppq_pkg::rec_type);

   typedef enum logic [6:0] {
      S_IDLE     = 7'b0000001,
      S_SCAN_RD  = 7'b0000010,
      S_SCAN_CHK = 7'b0000100,
      S_SHIFT_RD = 7'b0001000,
      S_SHIFT_WR = 7'b0010000,
      S_PUT      = 7'b0100000,
      S_DONE     = 7'b1000000
   } state_type;

   state_type              state_ff, state_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [CW-1:0]          idx_ff, idx_in;
   logic [CW-1:0]          pos_ff, pos_in;
   ppq_pkg::func_type      func_ff, func_in;
   ppq_pkg::rec_type       key_ff, key_in;
   ppq_pkg::status_type    res_status_ff, res_status_in;
   ppq_pkg::rec_type       res_rec_ff, res_rec_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   ppq_pkg::status_type    rsp_status_ff, rsp_status_in;
   ppq_pkg::rec_type       rsp_rec_ff, rsp_rec_in;
   logic [CW-1:0]          rsp_occ_ff, rsp_occ_in;

   logic                   wr_en;
   logic [AW-1:0]          wr_addr;
   logic [RW-1:0]          wr_data;
   logic [AW-1:0]          rd_addr;
   logic [RW-1:0]          rd_data;
   ppq_pkg::rec_type       rd_rec;
   ppq_pkg::cmp_mode_type  cmp_mode;
   logic                   hit;
   logic [CW-1:0]          idx_p1;
   logic [CW-1:0]          idx_m1;
   logic [CW-1:0]          idx_p2;
   logic                   is_insert;
   logic                   req_accept;
   ppq_pkg::rec_type       req_rec;
   logic [CW+4:0]          occ_wide;

   ppq_ram #(
      .WIDTH (RW),
      .DEPTH (QUEUE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   ppq_cmp u_cmp (
      .mode  (cmp_mode),
      .entry (rd_rec),
      .key   (key_ff),
      .hit   (hit)
   );

   assign rd_rec    = ppq_pkg::rec_type'(rd_data);
   assign idx_p1    = idx_ff + CW'(1);
   assign idx_m1    = idx_ff - CW'(1);
   assign idx_p2    = idx_ff + CW'(2);
   assign is_insert = (func_ff == ppq_pkg::FUNC_INSERT);

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_accept     = req_chan.valid && (state_ff == S_IDLE);

   assign req_rec.id      = req_chan.proc_id;
   assign req_rec.arrival = req_chan.arrival;
   assign req_rec.burst   = req_chan.burst;
   assign req_rec.prio    = req_chan.prio;

   always_comb begin
      case (func_ff)
         ppq_pkg::FUNC_INSERT: cmp_mode = ppq_pkg::CMP_PRIO;
         ppq_pkg::FUNC_REMOVE: cmp_mode = ppq_pkg::CMP_ID;
         default:              cmp_mode = ppq_pkg::CMP_ANY;
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      pos_in        = pos_ff;
      func_in       = func_ff;
      key_in        = key_ff;
      res_status_in = res_status_ff;
      res_rec_in    = res_rec_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_rec_in    = rsp_rec_ff;
      rsp_occ_in    = rsp_occ_ff;
      wr_en         = 1'b0;
      wr_addr       = idx_ff[AW-1:0];
      wr_data       = rd_data;
      rd_addr       = idx_ff[AW-1:0];

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               func_in = ppq_pkg::func_type'(req_chan.func);
               key_in  = req_rec;
               idx_in  = '0;
               if (req_chan.func == ppq_pkg::FUNC_INSERT ||
                   req_chan.func == ppq_pkg::FUNC_APPEND) begin
                  if (count_ff == CW'(QUEUE_DEPTH)) begin
                     res_status_in = ppq_pkg::STATUS_FULL;
                     res_rec_in    = '0;
                     state_in      = S_DONE;
                  end else if (req_chan.func == ppq_pkg::FUNC_APPEND ||
                               count_ff == '0) begin
                     pos_in   = count_ff;
                     state_in = S_PUT;
                  end else begin
                     state_in = S_SCAN_RD;
                  end
               end else if (count_ff == '0) begin
                  res_status_in = ppq_pkg::STATUS_EMPTY;
                  res_rec_in    = '0;
                  state_in      = S_DONE;
               end else begin
                  state_in = S_SCAN_RD;
               end
            end
         end
         S_SCAN_RD: begin
            state_in = S_SCAN_CHK;
         end
         S_SCAN_CHK: begin
            if (hit) begin
               if (is_insert) begin
                  // open a gap at the match: shift from the tail downwards
                  pos_in   = idx_ff;
                  idx_in   = count_ff;
                  state_in = S_SHIFT_RD;
               end else begin
                  res_rec_in    = rd_rec;
                  res_status_in = ppq_pkg::STATUS_OK;
                  if (idx_p1 == count_ff) begin
                     count_in = count_ff - CW'(1);
                     state_in = S_DONE;
                  end else begin
                     state_in = S_SHIFT_RD;
                  end
               end
            end else if (idx_p1 == count_ff) begin
               if (is_insert) begin
                  pos_in   = count_ff;
                  state_in = S_PUT;
               end else begin
                  res_status_in = ppq_pkg::STATUS_NOT_FOUND;
                  res_rec_in    = '0;
                  state_in      = S_DONE;
               end
            end else begin
               idx_in   = idx_p1;
               state_in = S_SCAN_RD;
            end
         end
         S_SHIFT_RD: begin
            rd_addr  = is_insert ? idx_m1[AW-1:0] : idx_p1[AW-1:0];
            state_in = S_SHIFT_WR;
         end
         S_SHIFT_WR: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff[AW-1:0];
            wr_data = rd_data;
            if (is_insert) begin
               idx_in   = idx_m1;
               state_in = (idx_m1 == pos_ff) ? S_PUT : S_SHIFT_RD;
            end else begin
               idx_in = idx_p1;
               if (idx_p2 == count_ff) begin
                  count_in = count_ff - CW'(1);
                  state_in = S_DONE;
               end else begin
                  state_in = S_SHIFT_RD;
               end
            end
         end
         S_PUT: begin
            wr_en         = 1'b1;
            wr_addr       = pos_ff[AW-1:0];
            wr_data       = key_ff;
            count_in      = count_ff + CW'(1);
            res_status_in = ppq_pkg::STATUS_OK;
            res_rec_in    = key_ff;
            state_in      = S_DONE;
         end
         S_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_rec_in    = res_rec_ff;
               rsp_occ_in    = count_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      pos_ff        <= pos_in;
      func_ff       <= func_in;
      key_ff        <= key_in;
      res_status_ff <= res_status_in;
      res_rec_ff    <= res_rec_in;
      rsp_status_ff <= rsp_status_in;
      rsp_rec_ff    <= rsp_rec_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   assign occ_wide = (CW + 5)'(rsp_occ_ff);

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.out_id      = rsp_rec_ff.id;
   assign rsp_chan.out_arrival = rsp_rec_ff.arrival;
   assign rsp_chan.out_burst   = rsp_rec_ff.burst;
   assign rsp_chan.out_prio    = rsp_rec_ff.prio;
   assign rsp_chan.occupancy   = occ_wide[4:0];

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(QUEUE_DEPTH))
      else $error("record count beyond queue depth");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("response raised outside completion");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != ppq_pkg::STATUS_OK) |->
      (rsp_rec_ff.id == '0 && rsp_rec_ff.prio == '0 && rsp_rec_ff.burst == '0))
      else $error("failed operation returned a record");

endmodule

/* dv/tb.sv */
`timescale 1ns / 100ps
// Testbench for the process priority queue: directed and random queue
// operations checked against a shadow queue. Depends on ppq_pkg, ppq_if and
// process_priority_queue.
module tb;

   localparam int QUEUE_DEPTH = 16;
   localparam int HOLD_CYCLES = 300;
   localparam int SETTLE_CYCLES = 60;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct {
      ppq_pkg::status_type  status;
      ppq_pkg::rec_type     rec;
      logic [4:0]           occupancy;
   } op_outcome_type;

   logic clock;
   logic reset;

   ppq_req_if req_chan ();
   ppq_rsp_if rsp_chan ();

   process_priority_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   ppq_pkg::rec_type shadow_recs[$];
   op_outcome_type   outcomes_due[$];
   op_outcome_type   got_outcome;
   int               err_count = 0;
   int               cycle_count = 0;
   int               send_idle_pct = 22;
   int               rcv_idle_pct = 52;
   int               hold_arm = 0;

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb: done, errors");
         $finish;
      end
   end

   // Shadow of the queue: apply one operation and return what the block owes.
   function automatic op_outcome_type shadow_queue_op(input ppq_pkg::func_type f,
                                                      input ppq_pkg::rec_type r);
      op_outcome_type res;
      int pos;
      int i;
      res.status = ppq_pkg::STATUS_OK;
      res.rec = '0;
      case (f)
         ppq_pkg::FUNC_INSERT, ppq_pkg::FUNC_APPEND: begin
            if (shadow_recs.size() >= QUEUE_DEPTH) begin
               res.status = ppq_pkg::STATUS_FULL;
            end else begin
               pos = shadow_recs.size();
               if (f == ppq_pkg::FUNC_INSERT) begin
                  // new record goes ahead of equal priorities
                  for (i = 0; i < shadow_recs.size(); i++)
                     if (pos == shadow_recs.size() && shadow_recs[i].prio >= r.prio)
                        pos = i;
               end
               shadow_recs.insert(pos, r);
               res.rec = r;
            end
         end
         ppq_pkg::FUNC_POP: begin
            if (shadow_recs.size() == 0)
               res.status = ppq_pkg::STATUS_EMPTY;
            else
               res.rec = shadow_recs.pop_front();
         end
         default: begin
            if (shadow_recs.size() == 0) begin
               res.status = ppq_pkg::STATUS_EMPTY;
            end else begin
               pos = -1;
               for (i = 0; i < shadow_recs.size(); i++)
                  if (pos < 0 && shadow_recs[i].id == r.id)
                     pos = i;
               if (pos < 0) begin
                  res.status = ppq_pkg::STATUS_NOT_FOUND;
               end else begin
                  res.rec = shadow_recs[pos];
                  shadow_recs.delete(pos);
               end
            end
         end
      endcase
      res.occupancy = 5'(shadow_recs.size());
      return res;
   endfunction

   function automatic void check_field(input string what, input logic [15:0] want_v,
                                       input logic [15:0] got_v);
      if (got_v !== want_v) begin
         $display("%0t tb: %s mismatch, expected %h, actual %h", $time, what, want_v, got_v);
         err_count++;
      end
   endfunction

   // Check each response transfer first, then predict any request transfer.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (outcomes_due.size() == 0) begin
               $display("%0t tb: response with none due, actual status %h id %h",
                        $time, rsp_chan.status, rsp_chan.out_id);
               err_count++;
            end else begin
               got_outcome = outcomes_due.pop_front();
               check_field("status", 16'(got_outcome.status), 16'(rsp_chan.status));
               check_field("out_id", got_outcome.rec.id, rsp_chan.out_id);
               check_field("out_arrival", got_outcome.rec.arrival, rsp_chan.out_arrival);
               check_field("out_burst", got_outcome.rec.burst, rsp_chan.out_burst);
               check_field("out_prio", 16'(got_outcome.rec.prio), 16'(rsp_chan.out_prio));
               check_field("occupancy", 16'(got_outcome.occupancy),
                           16'(rsp_chan.occupancy));
            end
         end
         if (req_chan.valid && req_chan.ready)
            outcomes_due.insert(outcomes_due.size(),
               shadow_queue_op(ppq_pkg::func_type'(req_chan.func),
                  ppq_pkg::rec_type'{req_chan.proc_id, req_chan.arrival,
                                     req_chan.burst, req_chan.prio}));
      end
   end

   // Response side: random stalls, plus a long hold-off when armed.
   initial begin : rsp_drive
      int hold_seen;
      int hold_left;
      hold_seen = 0;
      hold_left = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_arm != hold_seen) begin
            hold_seen = hold_arm;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= rcv_idle_pct);
         end
      end
   end

   // Offer one request and hold it until the transfer; valid stays high after.
   task automatic issue_op(input ppq_pkg::func_type f, input logic [15:0] id,
                           input logic [15:0] arrival, input logic [15:0] burst,
                           input logic [7:0] prio);
      if ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_chan.valid <= 1'b1;
      req_chan.func <= f;
      req_chan.proc_id <= id;
      req_chan.arrival <= arrival;
      req_chan.burst <= burst;
      req_chan.prio <= prio;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (outcomes_due.size() != 0);
   endtask

   task automatic test_empty_queue();
      issue_op(ppq_pkg::FUNC_POP, 16'h0000, 16'h0000, 16'h0000, 8'h00);
      issue_op(ppq_pkg::FUNC_REMOVE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF);
   endtask

   task automatic test_ordering();
      issue_op(ppq_pkg::FUNC_INSERT, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF);
      issue_op(ppq_pkg::FUNC_INSERT, 16'h0000, 16'h0000, 16'h0000, 8'h00);
      issue_op(ppq_pkg::FUNC_INSERT, 16'h0005, 16'h1234, 16'h00AA, 8'h80);
      issue_op(ppq_pkg::FUNC_INSERT, 16'h0006, 16'h5678, 16'h0055, 8'h80);
      // append ignores priority
      issue_op(ppq_pkg::FUNC_APPEND, 16'h0007, 16'h0001, 16'h0002, 8'h00);
      issue_op(ppq_pkg::FUNC_REMOVE, 16'h1234, 16'h0000, 16'h0000, 8'h00);
      issue_op(ppq_pkg::FUNC_REMOVE, 16'h0007, 16'h0000, 16'h0000, 8'h00);
      issue_op(ppq_pkg::FUNC_REMOVE, 16'h0000, 16'h0000, 16'h0000, 8'h00);
      issue_op(ppq_pkg::FUNC_REMOVE, 16'h0005, 16'h0000, 16'h0000, 8'h00);
   endtask

   task automatic test_full_queue();
      int n;
      for (n = 0; n < QUEUE_DEPTH - 2; n++)
         issue_op(ppq_pkg::FUNC_INSERT, 16'($urandom_range(65535)),
                  16'($urandom_range(65535)), 16'($urandom_range(65535)),
                  8'($urandom_range(255)));
      issue_op(ppq_pkg::FUNC_INSERT, 16'hAAAA, 16'h5555, 16'hAAAA, 8'h00);
      issue_op(ppq_pkg::FUNC_APPEND, 16'h5555, 16'hAAAA, 16'h5555, 8'hFF);
   endtask

   // Mostly well-formed traffic that swings between filling and draining,
   // with a little fully random noise.
   task automatic test_random_ops(input int count);
      int n;
      int roll;
      bit filling;
      ppq_pkg::func_type f;
      logic [15:0] id;
      logic [7:0] prio;
      filling = 1'b1;
      for (n = 0; n < count; n++) begin
         if (shadow_recs.size() >= QUEUE_DEPTH)
            filling = 1'b0;
         else if (shadow_recs.size() == 0)
            filling = 1'b1;
         roll = $urandom_range(99);
         id = ($urandom_range(1) != 0) ? 16'($urandom_range(15)) :
                                         16'($urandom_range(65535));
         prio = ($urandom_range(99) < 40) ? 8'($urandom_range(7)) :
                                            8'($urandom_range(255));
         if (roll < 5)
            f = ppq_pkg::func_type'(2'($urandom_range(3)));
         else if ((filling && roll < 70) || (!filling && roll < 30))
            f = ($urandom_range(1) != 0) ? ppq_pkg::FUNC_INSERT : ppq_pkg::FUNC_APPEND;
         else
            f = ($urandom_range(1) != 0) ? ppq_pkg::FUNC_POP : ppq_pkg::FUNC_REMOVE;
         if (f == ppq_pkg::FUNC_REMOVE && roll >= 5 && shadow_recs.size() != 0
             && $urandom_range(99) < 70)
            id = shadow_recs[$urandom_range(shadow_recs.size() - 1)].id;
         issue_op(f, id, 16'($urandom_range(65535)), 16'($urandom_range(65535)), prio);
      end
   endtask

   // Hold off the response side while requests keep coming.
   task automatic test_backpressure();
      int saved_pct;
      saved_pct = send_idle_pct;
      send_idle_pct = 0;
      hold_arm++;
      test_random_ops(24);
      send_idle_pct = saved_pct;
      wait_drained();
   endtask

   initial begin
      reset <= 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.func <= ppq_pkg::FUNC_INSERT;
      req_chan.proc_id <= '0;
      req_chan.arrival <= '0;
      req_chan.burst <= '0;
      req_chan.prio <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_empty_queue();
      test_ordering();
      test_full_queue();
      wait_drained();

      test_random_ops(540);
      test_backpressure();
      wait_drained();

      send_idle_pct = 52;
      rcv_idle_pct = 22;
      test_random_ops(540);
      wait_drained();

      send_idle_pct = 0;
      rcv_idle_pct = 0;
      test_random_ops(540);
      wait_drained();

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (err_count == 0 && outcomes_due.size() == 0)
         $display("tb: done, clean");
      else
         $display("tb: done, errors");
      $finish;
   end

endmodule
